// ===== rtl/alvr_pkg.sv =====
// Shared constants for the acceleration-limited velocity ramp generator.
// Command, status and register index codes, field widths and reset values.
// No dependencies.
`timescale 1ns / 1ps

package alvr_pkg;

  localparam int QUEUE_DEPTH     = 16;
  localparam int VELOCITY_WIDTH  = 32;
  localparam int HOLD_WIDTH      = 24;
  localparam int INDEX_WIDTH     = 32;
  localparam int ACCEL_WIDTH     = 48;
  localparam int ACCEL_FRAC      = 16;
  localparam int STEP_WIDTH      = 31;
  localparam int VLIM_WIDTH      = 31;
  localparam int INV_DT_WIDTH    = 32;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int COMMAND_WIDTH   = 2;
  localparam int STATUS_WIDTH    = 3;

  localparam logic [COMMAND_WIDTH-1:0] CMD_START = 2'd0;
  localparam logic [COMMAND_WIDTH-1:0] CMD_PUSH  = 2'd1;
  localparam logic [COMMAND_WIDTH-1:0] CMD_TICK  = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_SAMPLE    = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_NO_SAMPLE = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_ACCEPTED  = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_TOO_FAST  = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 3'd4;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_STEP     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_VELOCITY = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INV_DT       = 2'd2;

  localparam logic [STEP_WIDTH-1:0]   MAX_STEP_RESET     = 31'd65536;
  localparam logic [VLIM_WIDTH-1:0]   MAX_VELOCITY_RESET = 31'h7FFF_FFFF;
  localparam logic [INV_DT_WIDTH-1:0] INV_DT_RESET       = 32'd65536;

  localparam logic [ACCEL_WIDTH-1:0] ACCEL_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [ACCEL_WIDTH-1:0] ACCEL_NEG_MAG = 48'h8000_0000_0000;

endpackage

// ===== rtl/accel_limited_velocity_ramp_top.sv =====
// Acceleration-limited velocity ramp generator, top level.
// Depends on alvr_pkg and alvr_ram.
//
// Usage:
// Requests enter on the in_ channel (valid/ready) and carry a command, a
// velocity and a hold time. Every request gives exactly one result on the
// out_ channel (valid/ready): a status, and for status sample the velocity,
// the acceleration and the sample index. Start sets the current velocity,
// push queues a target, tick steps the ramp or holds the target.
// Requests pass the input, B, C, D and output registers. Throughput is one
// request per cycle unless out_ready stalls: queue and ramp state update in
// a single stage; the acceleration multiply and rounding sit in later stages.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes one of
// max_step, max_velocity and inv_dt per write; write it only while no request
// is in flight. Reset empties the queue, returns to idle (ticks give no sample
// before a start) and loads the register defaults. When the receiver stalls,
// the five pipeline registers fill one by one and in_ready falls only when
// all of them hold a request.
`timescale 1ns / 1ps

module accel_limited_velocity_ramp_top #(
  parameter int QUEUE_DEPTH    = alvr_pkg::QUEUE_DEPTH,
  parameter int VELOCITY_WIDTH = alvr_pkg::VELOCITY_WIDTH
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [alvr_pkg::COMMAND_WIDTH-1:0]       in_command,
  input  logic signed [VELOCITY_WIDTH-1:0]         in_velocity,
  input  logic [alvr_pkg::HOLD_WIDTH-1:0]          in_hold_ticks,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [alvr_pkg::STATUS_WIDTH-1:0]        out_status,
  output logic signed [VELOCITY_WIDTH-1:0]         out_sample_velocity,
  output logic signed [alvr_pkg::ACCEL_WIDTH-1:0]  out_sample_accel,
  output logic [alvr_pkg::INDEX_WIDTH-1:0]         out_sample_index,
  input  logic                                     cfg_we,
  input  logic [alvr_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [alvr_pkg::CFG_DATA_WIDTH-1:0]      cfg_wdata
);

  localparam int VW   = VELOCITY_WIDTH;
  localparam int HW   = alvr_pkg::HOLD_WIDTH;
  localparam int IW   = alvr_pkg::INDEX_WIDTH;
  localparam int SW   = alvr_pkg::STATUS_WIDTH;
  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int FW   = $clog2(QUEUE_DEPTH + 1);
  localparam int QW   = VW + HW;
  localparam int MW   = (VW > alvr_pkg::VLIM_WIDTH) ? VW : alvr_pkg::VLIM_WIDTH;
  localparam int OFFW = (VW + 1 > 32) ? VW + 1 : 32;
  localparam int PW   = VW + 1 + alvr_pkg::INV_DT_WIDTH;
  localparam int RW   = (PW - alvr_pkg::ACCEL_FRAC > alvr_pkg::ACCEL_WIDTH + 1) ?
                        PW - alvr_pkg::ACCEL_FRAC : alvr_pkg::ACCEL_WIDTH + 1;
  localparam int XW   = alvr_pkg::ACCEL_WIDTH;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READY,
    PH_RAMP,
    PH_HOLD
  } phase_t;

  // Configuration registers.
  logic [alvr_pkg::STEP_WIDTH-1:0]   max_step_r;
  logic [alvr_pkg::VLIM_WIDTH-1:0]   max_velocity_r;
  logic [alvr_pkg::INV_DT_WIDTH-1:0] inv_dt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r     <= alvr_pkg::MAX_STEP_RESET;
      max_velocity_r <= alvr_pkg::MAX_VELOCITY_RESET;
      inv_dt_r       <= alvr_pkg::INV_DT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        alvr_pkg::REG_MAX_STEP: begin
          max_step_r <= cfg_wdata[alvr_pkg::STEP_WIDTH-1:0];
        end
        alvr_pkg::REG_MAX_VELOCITY: begin
          max_velocity_r <= cfg_wdata[alvr_pkg::VLIM_WIDTH-1:0];
        end
        alvr_pkg::REG_INV_DT: begin
          inv_dt_r <= cfg_wdata[alvr_pkg::INV_DT_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline valids and enables.
  logic a_valid_r, b_valid_r, c_valid_r, d_valid_r, o_valid_r;
  logic en_a, en_b, en_c, en_d, en_o;
  logic b_fire;

  assign en_o     = !o_valid_r || out_ready;
  assign en_d     = !d_valid_r || en_o;
  assign en_c     = !c_valid_r || en_d;
  assign en_b     = !b_valid_r || en_c;
  assign en_a     = !a_valid_r || en_b;
  assign in_ready = en_a;
  assign b_fire   = a_valid_r && en_b;

  // Input register.
  logic [alvr_pkg::COMMAND_WIDTH-1:0] a_cmd_r;
  logic signed [VW-1:0]               a_vel_r;
  logic [HW-1:0]                      a_hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en_a) begin
      a_valid_r <= in_valid;
      a_cmd_r   <= in_command;
      a_vel_r   <= in_velocity;
      a_hold_r  <= in_hold_ticks;
    end
  end

  // Ramp and queue state.
  phase_t               phase_r, phase_nxt;
  logic signed [VW-1:0] cur_r, cur_nxt;
  logic signed [VW-1:0] origin_r, origin_nxt;
  logic [VW:0]          gap_mag_r, gap_mag_nxt;
  logic                 gap_neg_r, gap_neg_nxt;
  logic [OFFW-1:0]      offset_r, offset_nxt;
  logic signed [VW-1:0] target_r, target_nxt;
  logic [HW-1:0]        hold_r, hold_nxt;
  logic [IW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        tail_r, tail_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;

  logic [SW-1:0]        b_status_r, b_status_nxt;
  logic signed [VW-1:0] b_vel_r, b_vel_nxt;
  logic signed [VW-1:0] b_prev_r, b_prev_nxt;
  logic [IW-1:0]        b_idx_r, b_idx_nxt;

  // Target queue.
  logic          q_we;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;
  logic [QW-1:0] q_word;
  logic          byp_valid_r;
  logic [QW-1:0] byp_data_r;

  alvr_ram #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (q_wdata),
    .raddr (head_nxt),
    .rdata (q_rdata)
  );

  assign q_wdata = {a_hold_r, a_vel_r};
  assign q_word  = byp_valid_r ? byp_data_r : q_rdata;

  // Stage B combinational work.
  logic [VW-1:0]        vmag;
  logic                 too_fast;
  logic signed [VW-1:0] q_vel;
  logic [HW-1:0]        q_hold;
  logic [VW:0]          pop_diff;
  logic                 pop_neg;
  logic [VW:0]          pop_mag;
  logic [OFFW-1:0]      step_ext;
  logic signed [VW-1:0] origin_e;
  logic [VW:0]          gmag_e;
  logic                 gneg_e;
  logic [OFFW-1:0]      offset_e;
  logic signed [VW-1:0] target_e;
  logic [HW-1:0]        hold_e;
  logic                 step_ramp;
  logic                 step_hold;
  logic [OFFW-1:0]      off_sum;
  logic signed [VW-1:0] emit_v;

  assign vmag     = a_vel_r[VW-1] ? ('0 - a_vel_r) : a_vel_r;
  assign too_fast = MW'(vmag) > MW'(max_velocity_r);
  assign q_vel    = q_word[VW-1:0];
  assign q_hold   = q_word[QW-1:VW];
  assign pop_diff = {q_vel[VW-1], q_vel} - {cur_r[VW-1], cur_r};
  assign pop_neg  = pop_diff[VW];
  assign pop_mag  = pop_neg ? ('0 - pop_diff) : pop_diff;
  assign step_ext = (max_step_r == '0) ? OFFW'(1) : OFFW'(max_step_r);

  always_comb begin
    phase_nxt    = phase_r;
    cur_nxt      = cur_r;
    origin_nxt   = origin_r;
    gap_mag_nxt  = gap_mag_r;
    gap_neg_nxt  = gap_neg_r;
    offset_nxt   = offset_r;
    target_nxt   = target_r;
    hold_nxt     = hold_r;
    count_nxt    = count_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    q_we         = 1'b0;
    b_status_nxt = alvr_pkg::ST_NO_SAMPLE;
    b_vel_nxt    = '0;
    b_prev_nxt   = '0;
    b_idx_nxt    = '0;
    origin_e     = origin_r;
    gmag_e       = gap_mag_r;
    gneg_e       = gap_neg_r;
    offset_e     = offset_r;
    target_e     = target_r;
    hold_e       = hold_r;
    step_ramp    = 1'b0;
    step_hold    = 1'b0;
    off_sum      = '0;
    emit_v       = target_r;
    if (b_fire) begin
      case (a_cmd_r)
        alvr_pkg::CMD_START: begin
          if (too_fast) begin
            b_status_nxt = alvr_pkg::ST_TOO_FAST;
          end else begin
            cur_nxt      = a_vel_r;
            count_nxt    = '0;
            phase_nxt    = PH_READY;
            b_status_nxt = alvr_pkg::ST_SAMPLE;
            b_vel_nxt    = a_vel_r;
            b_prev_nxt   = a_vel_r;
          end
        end
        alvr_pkg::CMD_PUSH: begin
          if (too_fast) begin
            b_status_nxt = alvr_pkg::ST_TOO_FAST;
          end else if (fill_r == FW'(QUEUE_DEPTH)) begin
            b_status_nxt = alvr_pkg::ST_FULL;
          end else begin
            q_we         = 1'b1;
            tail_nxt     = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
            fill_nxt     = fill_r + 1'b1;
            b_status_nxt = alvr_pkg::ST_ACCEPTED;
          end
        end
        alvr_pkg::CMD_TICK: begin
          if (phase_r == PH_READY && fill_r != '0) begin
            head_nxt    = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            fill_nxt    = fill_r - 1'b1;
            target_nxt  = q_vel;
            hold_nxt    = q_hold;
            origin_nxt  = cur_r;
            gap_neg_nxt = pop_neg;
            gap_mag_nxt = pop_mag;
            offset_nxt  = '0;
            origin_e    = cur_r;
            gmag_e      = pop_mag;
            gneg_e      = pop_neg;
            offset_e    = '0;
            target_e    = q_vel;
            hold_e      = q_hold;
            if (pop_mag != '0) begin
              step_ramp = 1'b1;
            end else if (q_hold != '0) begin
              step_hold = 1'b1;
            end
          end else if (phase_r == PH_RAMP) begin
            step_ramp = 1'b1;
          end else if (phase_r == PH_HOLD) begin
            step_hold = 1'b1;
          end

          if (step_ramp) begin
            off_sum    = offset_e + step_ext;
            offset_nxt = off_sum;
            phase_nxt  = PH_RAMP;
            if (off_sum >= OFFW'(gmag_e)) begin
              phase_nxt = (hold_e != '0) ? PH_HOLD : PH_READY;
              emit_v    = target_e;
            end else if (gneg_e) begin
              emit_v = origin_e - off_sum[VW-1:0];
            end else begin
              emit_v = origin_e + off_sum[VW-1:0];
            end
          end else if (step_hold) begin
            hold_nxt  = hold_e - 1'b1;
            phase_nxt = (hold_e == HW'(1)) ? PH_READY : PH_HOLD;
            emit_v    = target_e;
          end

          if (step_ramp || step_hold) begin
            cur_nxt      = emit_v;
            count_nxt    = count_r + 1'b1;
            b_status_nxt = alvr_pkg::ST_SAMPLE;
            b_vel_nxt    = emit_v;
            b_prev_nxt   = cur_r;
            b_idx_nxt    = count_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cur_r       <= '0;
      origin_r    <= '0;
      gap_mag_r   <= '0;
      gap_neg_r   <= 1'b0;
      offset_r    <= '0;
      target_r    <= '0;
      hold_r      <= '0;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      byp_valid_r <= 1'b0;
      b_valid_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cur_r       <= cur_nxt;
      origin_r    <= origin_nxt;
      gap_mag_r   <= gap_mag_nxt;
      gap_neg_r   <= gap_neg_nxt;
      offset_r    <= offset_nxt;
      target_r    <= target_nxt;
      hold_r      <= hold_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      byp_valid_r <= q_we && (tail_r == head_nxt);
      byp_data_r  <= q_wdata;
      if (en_b) begin
        b_valid_r  <= a_valid_r;
        b_status_r <= b_status_nxt;
        b_vel_r    <= b_vel_nxt;
        b_prev_r   <= b_prev_nxt;
        b_idx_r    <= b_idx_nxt;
      end
    end
  end

  // Stage C: velocity change as sign and magnitude.
  logic [VW:0]          b_diff;
  logic [SW-1:0]        c_status_r;
  logic signed [VW-1:0] c_vel_r;
  logic [IW-1:0]        c_idx_r;
  logic [VW:0]          c_mag_r;
  logic                 c_neg_r;

  assign b_diff = {b_vel_r[VW-1], b_vel_r} - {b_prev_r[VW-1], b_prev_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en_c) begin
      c_valid_r  <= b_valid_r;
      c_status_r <= b_status_r;
      c_vel_r    <= b_vel_r;
      c_idx_r    <= b_idx_r;
      c_neg_r    <= b_diff[VW];
      c_mag_r    <= b_diff[VW] ? ('0 - b_diff) : b_diff;
    end
  end

  // Stage D: scale by the reciprocal tick period.
  logic [SW-1:0]        d_status_r;
  logic signed [VW-1:0] d_vel_r;
  logic [IW-1:0]        d_idx_r;
  logic [PW-1:0]        d_prod_r;
  logic                 d_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (en_d) begin
      d_valid_r  <= c_valid_r;
      d_status_r <= c_status_r;
      d_vel_r    <= c_vel_r;
      d_idx_r    <= c_idx_r;
      d_neg_r    <= c_neg_r;
      d_prod_r   <= PW'(c_mag_r) * PW'(inv_dt_r);
    end
  end

  // Output stage: round half away from zero, saturate, restore the sign.
  logic [PW-1:0] rnd;
  logic [RW-1:0] r_ext;
  logic [RW-1:0] limit;
  logic [RW-1:0] r_sat;
  logic [XW-1:0] acc_mag;
  logic [XW-1:0] acc;

  assign rnd     = d_prod_r + (PW'(1) << (alvr_pkg::ACCEL_FRAC - 1));
  assign r_ext   = RW'(rnd[PW-1:alvr_pkg::ACCEL_FRAC]);
  assign limit   = d_neg_r ? RW'(alvr_pkg::ACCEL_NEG_MAG) : RW'(alvr_pkg::ACCEL_POS_MAX);
  assign r_sat   = (r_ext > limit) ? limit : r_ext;
  assign acc_mag = r_sat[XW-1:0];
  assign acc     = d_neg_r ? ('0 - acc_mag) : acc_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (en_o) begin
      o_valid_r           <= d_valid_r;
      out_status          <= d_status_r;
      out_sample_velocity <= d_vel_r;
      out_sample_accel    <= acc;
      out_sample_index    <= d_idx_r;
    end
  end

  assign out_valid = o_valid_r;

endmodule

// ===== rtl/alvr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the target queue. Depends on alvr_pkg for default sizes.
`timescale 1ns / 1ps

module alvr_ram #(
  parameter int WIDTH = alvr_pkg::VELOCITY_WIDTH + alvr_pkg::HOLD_WIDTH,
  parameter int DEPTH = alvr_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== test/accel_limited_velocity_ramp_top_tb.sv =====
// Self-checking testbench for accel_limited_velocity_ramp_top.
// A scoreboard class predicts every result from its own copy of the ramp state
// and compares it with the block output. Depends on alvr_pkg and the block RTL.
`timescale 1ns / 1ps

module accel_limited_velocity_ramp_top_tb;

  typedef logic [alvr_pkg::COMMAND_WIDTH-1:0] cmd_t;
  typedef logic [alvr_pkg::HOLD_WIDTH-1:0]    hold_t;

  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int RANDOM_PER_PHASE = 215;

  typedef enum logic [1:0] {
    RAMP_IDLE,
    RAMP_READY,
    RAMP_STEPPING,
    RAMP_HOLDING
  } ramp_phase_t;

  typedef struct {
    logic [alvr_pkg::STATUS_WIDTH-1:0]          status;
    logic signed [alvr_pkg::VELOCITY_WIDTH-1:0] velocity;
    logic signed [alvr_pkg::ACCEL_WIDTH-1:0]    accel;
    logic [alvr_pkg::INDEX_WIDTH-1:0]           index;
  } ramp_result_t;

  class ramp_scoreboard;
    bit [alvr_pkg::STEP_WIDTH-1:0]   max_step;
    bit [alvr_pkg::VLIM_WIDTH-1:0]   max_velocity;
    bit [alvr_pkg::INV_DT_WIDTH-1:0] inv_dt;
    longint                          cur_vel;
    longint                          origin;
    longint                          target;
    longint unsigned                 gap;
    longint unsigned                 offset;
    bit                              gap_neg;
    ramp_phase_t                     phase;
    int unsigned                     hold_left;
    bit [alvr_pkg::INDEX_WIDTH-1:0]  sample_count;
    longint                          queue_vel[$];
    int unsigned                     queue_hold[$];
    ramp_result_t                    expected[$];
    int unsigned                     mismatches;
    int unsigned                     checked;
    int unsigned                     status_count[8];

    function new();
      max_step = alvr_pkg::MAX_STEP_RESET;
      max_velocity = alvr_pkg::MAX_VELOCITY_RESET;
      inv_dt = alvr_pkg::INV_DT_RESET;
      cur_vel = 0;
      origin = 0;
      target = 0;
      gap = 0;
      offset = 0;
      gap_neg = 1'b0;
      phase = RAMP_IDLE;
      hold_left = 0;
      sample_count = '0;
    endfunction

    function void write_reg(logic [alvr_pkg::CFG_INDEX_WIDTH-1:0] idx,
                            logic [alvr_pkg::CFG_DATA_WIDTH-1:0] data);
      case (idx)
        alvr_pkg::REG_MAX_STEP:     max_step = data[alvr_pkg::STEP_WIDTH-1:0];
        alvr_pkg::REG_MAX_VELOCITY: max_velocity = data[alvr_pkg::VLIM_WIDTH-1:0];
        alvr_pkg::REG_INV_DT:       inv_dt = data[alvr_pkg::INV_DT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function int queued();
      return queue_vel.size();
    endfunction

    function bit too_fast(longint v);
      longint mag;
      mag = (v < 0) ? -v : v;
      return mag > longint'(max_velocity);
    endfunction

    function logic [alvr_pkg::ACCEL_WIDTH-1:0] accel_for(longint change);
      bit neg;
      bit [65:0] mag;
      bit [65:0] rate;
      bit [65:0] prod;
      bit [65:0] lim;
      neg = change < 0;
      mag = neg ? -change : change;
      rate = inv_dt;
      lim = neg ? alvr_pkg::ACCEL_NEG_MAG : alvr_pkg::ACCEL_POS_MAX;
      prod = (mag * rate + 66'h8000) >> 16;
      if (prod > lim) begin
        prod = lim;
      end
      return neg ? -prod[alvr_pkg::ACCEL_WIDTH-1:0] : prod[alvr_pkg::ACCEL_WIDTH-1:0];
    endfunction

    function ramp_result_t emit(longint nv);
      ramp_result_t r;
      sample_count = sample_count + 1;
      r.status = alvr_pkg::ST_SAMPLE;
      r.velocity = nv[alvr_pkg::VELOCITY_WIDTH-1:0];
      r.accel = accel_for(nv - cur_vel);
      r.index = sample_count;
      cur_vel = nv;
      return r;
    endfunction

    function ramp_result_t next_tick();
      ramp_result_t r;
      longint diff;
      longint unsigned stride;
      longint nv;
      r.status = alvr_pkg::ST_NO_SAMPLE;
      r.velocity = '0;
      r.accel = '0;
      r.index = '0;
      if (phase == RAMP_IDLE) begin
        return r;
      end
      if (phase == RAMP_READY) begin
        if (queue_vel.size() == 0) begin
          return r;
        end
        target = queue_vel.pop_front();
        hold_left = queue_hold.pop_front();
        origin = cur_vel;
        diff = target - cur_vel;
        gap_neg = diff < 0;
        gap = gap_neg ? -diff : diff;
        offset = 0;
        if (gap != 0) begin
          phase = RAMP_STEPPING;
        end else if (hold_left != 0) begin
          phase = RAMP_HOLDING;
        end else begin
          return r;
        end
      end
      if (phase == RAMP_STEPPING) begin
        stride = (max_step == 0) ? 1 : max_step;
        offset += stride;
        if (offset >= gap) begin
          phase = (hold_left != 0) ? RAMP_HOLDING : RAMP_READY;
          nv = target;
        end else begin
          nv = gap_neg ? origin - longint'(offset) : origin + longint'(offset);
        end
      end else begin
        hold_left--;
        if (hold_left == 0) begin
          phase = RAMP_READY;
        end
        nv = target;
      end
      return emit(nv);
    endfunction

    function void note_request(cmd_t cmd,
                               logic signed [alvr_pkg::VELOCITY_WIDTH-1:0] vel,
                               hold_t hold);
      ramp_result_t r;
      longint v;
      v = vel;
      r.status = alvr_pkg::ST_NO_SAMPLE;
      r.velocity = '0;
      r.accel = '0;
      r.index = '0;
      case (cmd)
        alvr_pkg::CMD_START: begin
          if (too_fast(v)) begin
            r.status = alvr_pkg::ST_TOO_FAST;
          end else begin
            cur_vel = v;
            sample_count = '0;
            phase = RAMP_READY;
            r.status = alvr_pkg::ST_SAMPLE;
            r.velocity = vel;
          end
        end
        alvr_pkg::CMD_PUSH: begin
          if (too_fast(v)) begin
            r.status = alvr_pkg::ST_TOO_FAST;
          end else if (queue_vel.size() >= alvr_pkg::QUEUE_DEPTH) begin
            r.status = alvr_pkg::ST_FULL;
          end else begin
            queue_vel = {queue_vel, v};
            queue_hold = {queue_hold, int'(hold)};
            r.status = alvr_pkg::ST_ACCEPTED;
          end
        end
        alvr_pkg::CMD_TICK: r = next_tick();
        default: ;
      endcase
      status_count[r.status]++;
      expected = {expected, r};
    endfunction

    function void check_result(logic [alvr_pkg::STATUS_WIDTH-1:0] status,
                               logic signed [alvr_pkg::VELOCITY_WIDTH-1:0] vel,
                               logic signed [alvr_pkg::ACCEL_WIDTH-1:0] accel,
                               logic [alvr_pkg::INDEX_WIDTH-1:0] idx);
      ramp_result_t e;
      checked++;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result with no request pending: status %0d velocity %0d",
                   status, vel);
        end
        return;
      end
      e = expected.pop_front();
      if (status !== e.status || vel !== e.velocity || accel !== e.accel
          || idx !== e.index) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d: expected status %0d vel %0d accel %0d index %0d",
                   checked, e.status, e.velocity, e.accel, e.index);
          $display("       got status %0d vel %0d accel %0d index %0d",
                   status, vel, accel, idx);
        end
      end
    endfunction
  endclass

  logic                                       clk = 1'b0;
  logic                                       rst_n = 1'b0;
  logic                                       in_valid = 1'b0;
  logic                                       in_ready;
  cmd_t                                       in_command = alvr_pkg::CMD_TICK;
  logic signed [alvr_pkg::VELOCITY_WIDTH-1:0] in_velocity = '0;
  hold_t                                      in_hold_ticks = '0;
  logic                                       out_valid;
  logic                                       out_ready = 1'b0;
  logic [alvr_pkg::STATUS_WIDTH-1:0]          out_status;
  logic signed [alvr_pkg::VELOCITY_WIDTH-1:0] out_sample_velocity;
  logic signed [alvr_pkg::ACCEL_WIDTH-1:0]    out_sample_accel;
  logic [alvr_pkg::INDEX_WIDTH-1:0]           out_sample_index;
  logic                                       cfg_we = 1'b0;
  logic [alvr_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index = alvr_pkg::REG_MAX_STEP;
  logic [alvr_pkg::CFG_DATA_WIDTH-1:0]        cfg_wdata = '0;

  ramp_scoreboard sb = new();
  int unsigned    send_idle_pct = 9;
  int unsigned    recv_idle_pct = 86;
  int unsigned    requests_sent = 0;
  int unsigned    settings_used = 1;
  bit             hold_off_request = 1'b0;

  accel_limited_velocity_ramp_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_velocity        (in_velocity),
    .in_hold_ticks      (in_hold_ticks),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_sample_velocity(out_sample_velocity),
    .out_sample_accel   (out_sample_accel),
    .out_sample_index   (out_sample_index),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_request(input cmd_t cmd,
                              input logic signed [alvr_pkg::VELOCITY_WIDTH-1:0] vel,
                              input hold_t hold);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_velocity <= vel;
    in_hold_ticks <= hold;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sb.note_request(cmd, vel, hold);
    requests_sent++;
  endtask

  task automatic send_tick();
    send_request(alvr_pkg::CMD_TICK, $urandom, hold_t'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_regs(input logic [alvr_pkg::CFG_DATA_WIDTH-1:0] step,
                            input logic [alvr_pkg::CFG_DATA_WIDTH-1:0] vmax,
                            input logic [alvr_pkg::CFG_DATA_WIDTH-1:0] rate);
    cfg_we <= 1'b1;
    cfg_index <= alvr_pkg::REG_MAX_STEP;
    cfg_wdata <= step;
    sb.write_reg(alvr_pkg::REG_MAX_STEP, step);
    @(posedge clk);
    cfg_index <= alvr_pkg::REG_MAX_VELOCITY;
    cfg_wdata <= vmax;
    sb.write_reg(alvr_pkg::REG_MAX_VELOCITY, vmax);
    @(posedge clk);
    cfg_index <= alvr_pkg::REG_INV_DT;
    cfg_wdata <= rate;
    sb.write_reg(alvr_pkg::REG_INV_DT, rate);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [alvr_pkg::VELOCITY_WIDTH-1:0] pick_velocity(
      int unsigned scale);
    int unsigned sel;
    longint v;
    sel = $urandom_range(99);
    if (sel < 8) begin
      return $urandom;
    end
    if (sel < 16) begin
      v = longint'(sb.max_velocity) + $urandom_range(1);
      if ($urandom_range(1) == 1) begin
        v = -v;
      end
      return v[alvr_pkg::VELOCITY_WIDTH-1:0];
    end
    v = longint'($urandom_range(2 * scale)) - longint'(scale);
    return v[alvr_pkg::VELOCITY_WIDTH-1:0];
  endfunction

  function automatic hold_t pick_hold();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) begin
      return hold_t'($urandom);
    end
    return hold_t'($urandom_range(3));
  endfunction

  task automatic tick_until_idle(input int unsigned cap);
    int unsigned n;
    n = 0;
    while (sb.phase != RAMP_IDLE && !(sb.phase == RAMP_READY && sb.queued() == 0)
           && n < cap) begin
      send_tick();
      n++;
    end
  endtask

  task automatic run_random(input int unsigned scale, input int unsigned count);
    int unsigned stop_at;
    int unsigned sel;
    int unsigned pushes;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 12) begin
        send_request(cmd_t'($urandom_range(3)), $urandom, hold_t'($urandom));
      end else if (sel < 16) begin
        repeat (alvr_pkg::QUEUE_DEPTH + 2) begin
          send_request(alvr_pkg::CMD_PUSH, pick_velocity(scale), pick_hold());
        end
        tick_until_idle(120);
      end else begin
        send_request(alvr_pkg::CMD_START, pick_velocity(scale), hold_t'($urandom));
        pushes = $urandom_range(4, 1);
        repeat (pushes) send_request(alvr_pkg::CMD_PUSH, pick_velocity(scale), pick_hold());
        tick_until_idle(40);
      end
    end
  endtask

  initial begin : result_sink
    int unsigned hold_off_left;
    hold_off_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_status, out_sample_velocity, out_sample_accel, out_sample_index);
      end
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned scale;
    logic [alvr_pkg::CFG_DATA_WIDTH-1:0] step;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults after reset.
    send_tick();
    send_request(CMD_UNUSED, 32'sh1234_5678, 24'h00_00ff);
    send_request(alvr_pkg::CMD_PUSH, 32'sh0000_0000, 24'h00_0000);
    send_request(alvr_pkg::CMD_START, 32'sh8000_0000, 24'h00_0000);
    send_request(alvr_pkg::CMD_PUSH, 32'sh8000_0000, 24'h00_0000);
    send_request(alvr_pkg::CMD_START, 32'sh0000_0000, 24'h00_0000);
    send_tick();
    send_tick();
    send_request(alvr_pkg::CMD_PUSH, 32'sh0003_0000, 24'h00_0002);
    send_request(alvr_pkg::CMD_PUSH, -32'sh0001_8000, 24'h00_0000);
    repeat (11) send_tick();
    send_request(alvr_pkg::CMD_PUSH, 32'sh0000_0000, 24'hff_ffff);
    repeat (3) send_tick();
    send_request(alvr_pkg::CMD_START, 32'sh7fff_ffff, 24'h00_0000);
    send_request(alvr_pkg::CMD_START, -32'sh0001_0000, 24'h00_0000);
    drain();

    write_regs(32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(alvr_pkg::CMD_START, 32'sh7fff_ffff, 24'h00_0000);
    send_request(alvr_pkg::CMD_PUSH, 32'sh8000_0001, 24'hff_ffff);
    repeat (3) send_tick();
    send_request(alvr_pkg::CMD_START, 32'sh0000_0000, 24'h00_0000);
    send_request(alvr_pkg::CMD_PUSH, 32'sh8000_0000, 24'h00_0000);
    send_tick();
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_regs(32'd65536, 32'h7fff_ffff, 32'd65536);
          scale = 65536 * 6;
        end
        1: begin
          write_regs(32'd0, 32'd16, 32'd0);
          scale = 12;
        end
        2: begin
          send_idle_pct = 86;
          recv_idle_pct = 9;
          write_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
          scale = 32'h7fff_ffff;
        end
        3: begin
          write_regs(32'd1, 32'd0, 32'd1);
          scale = 3;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          step = $urandom_range(1 << 24, 1);
          write_regs(step, $urandom, $urandom);
          scale = (step > 32'h0fff_ffff) ? 32'h7fff_ffff : step * 8;
          if (p == 4) begin
            hold_off_request = 1'b1;
          end
        end
      endcase
      run_random(scale, RANDOM_PER_PHASE);
      drain();
    end

    $display("Checked %0d results over %0d requests and %0d register settings.",
             sb.checked, requests_sent, settings_used);
    $display("Samples %0d, no sample %0d, accepted %0d, too fast %0d, queue full %0d.",
             sb.status_count[alvr_pkg::ST_SAMPLE], sb.status_count[alvr_pkg::ST_NO_SAMPLE],
             sb.status_count[alvr_pkg::ST_ACCEPTED], sb.status_count[alvr_pkg::ST_TOO_FAST],
             sb.status_count[alvr_pkg::ST_FULL]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("ERROR: %0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
